// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Implication whose consequence is checked in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ----- hw/rtl/cc20_pkg.sv -----
// Types and constants shared by the ChaCha20 keystream blocks
package cc20_pkg;
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_NONCE0 = 3'd4;
  localparam logic [2:0] REG_NONCE1 = 3'd5;
  localparam logic [2:0] REG_START  = 3'd6;

  // Item passed from the front to the back
  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       last;
  } cc20_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FEED,
    ST_OUT
  } cc20_state_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    rotl32 = (v << n) | (v >> (32 - n));
  endfunction

  // One quarter-round on four words
  function automatic logic [127:0] qround(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] ta, tb, tc, td;
    ta = a + b; td = rotl32(d ^ ta, 16);
    tc = c + td; tb = rotl32(b ^ tc, 12);
    ta = ta + tb; td = rotl32(td ^ ta, 8);
    tc = tc + td; tb = rotl32(tb ^ tc, 7);
    qround = {td, tc, tb, ta};
  endfunction
endpackage

// ----- hw/rtl/cc20_front.sv -----
// Input skid queue: two-entry FIFO between the input channel and the cipher core
module cc20_front import cc20_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  cc20_item_t in_item,
  output logic       q_valid,
  input  logic       q_ready,
  output cc20_item_t q_item
);
  cc20_item_t  mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- hw/rtl/cc20_core.sv -----
// Block generator and byte XOR: one half round per cycle, then feed-forward
module cc20_core import cc20_pkg::*; #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [255:0] key,
  input  logic [63:0]  nonce01,
  input  logic [31:0]  nonce2,
  input  logic [63:0]  start_ctr,
  input  logic        q_valid,
  output logic        q_ready,
  input  cc20_item_t  q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last
);
  localparam int RW = $clog2(2 * DOUBLE_ROUNDS + 1);

  cc20_state_t  state_r, state_nxt;
  logic [31:0]  w_r [16];
  logic [31:0]  init_r [16];
  logic [31:0]  ks_r [16];
  logic [31:0]  ctr_lo_r, ctr_hi_r;
  logic [6:0]   pos_r;
  logic [RW-1:0] rnd_r;
  cc20_item_t   cur_r;
  logic         ov_r;
  logic [7:0]   ob_r;
  logic         ol_r;
  logic [31:0]  hr [16];
  logic [31:0]  ctr_lo_eff, ctr_hi_eff;
  logic         need_blk;
  logic [7:0]   ks_byte;

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;
  assign q_ready   = (state_r == ST_IDLE);

  // Effective counter after an optional restart
  always_comb begin
    ctr_lo_eff = q_item.restart ? start_ctr[31:0] : ctr_lo_r;
    ctr_hi_eff = q_item.restart ? nonce01[31:0] + start_ctr[63:32] : ctr_hi_r;
    need_blk   = q_item.restart || pos_r[6];
  end

  // One half round: columns on even steps, diagonals on odd steps
  always_comb begin
    if (!rnd_r[0]) begin
      {hr[12], hr[8], hr[4], hr[0]} = qround(w_r[0], w_r[4], w_r[8], w_r[12]);
      {hr[13], hr[9], hr[5], hr[1]} = qround(w_r[1], w_r[5], w_r[9], w_r[13]);
      {hr[14], hr[10], hr[6], hr[2]} = qround(w_r[2], w_r[6], w_r[10], w_r[14]);
      {hr[15], hr[11], hr[7], hr[3]} = qround(w_r[3], w_r[7], w_r[11], w_r[15]);
    end else begin
      {hr[15], hr[10], hr[5], hr[0]} = qround(w_r[0], w_r[5], w_r[10], w_r[15]);
      {hr[12], hr[11], hr[6], hr[1]} = qround(w_r[1], w_r[6], w_r[11], w_r[12]);
      {hr[13], hr[8], hr[7], hr[2]} = qround(w_r[2], w_r[7], w_r[8], w_r[13]);
      {hr[14], hr[9], hr[4], hr[3]} = qround(w_r[3], w_r[4], w_r[9], w_r[14]);
    end
  end

  assign ks_byte = ks_r[pos_r[5:2]][8*pos_r[1:0] +: 8];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (q_valid) state_nxt = need_blk ? ST_ROUND : ST_OUT;
      ST_ROUND: if (rnd_r == RW'(2 * DOUBLE_ROUNDS - 1)) state_nxt = ST_FEED;
      ST_FEED:  state_nxt = ST_OUT;
      ST_OUT:   if (!ov_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ctr_lo_r <= '0;
      ctr_hi_r <= '0;
      pos_r    <= 7'd64;
      rnd_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Load a new result or drop the one taken by the receiver
      if (state_r == ST_OUT && (!ov_r || out_ready)) begin
        ov_r <= 1'b1;
      end else if (ov_r && out_ready) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          rnd_r <= '0;
          if (q_valid && need_blk) begin
            ctr_lo_r <= ctr_lo_eff + 32'd1;
            ctr_hi_r <= (ctr_lo_eff == 32'hffffffff) ? ctr_hi_eff + 32'd1 : ctr_hi_eff;
          end
        end
        ST_ROUND: rnd_r <= rnd_r + RW'(1);
        ST_FEED:  pos_r <= 7'd0;
        ST_OUT: begin
          if (!ov_r || out_ready) begin
            pos_r <= pos_r + 7'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        cur_r <= q_item;
        if (q_valid && need_blk) begin
          init_r[0] <= SIGMA0; init_r[1] <= SIGMA1;
          init_r[2] <= SIGMA2; init_r[3] <= SIGMA3;
          w_r[0] <= SIGMA0; w_r[1] <= SIGMA1; w_r[2] <= SIGMA2; w_r[3] <= SIGMA3;
          for (int i = 0; i < 8; i++) begin
            init_r[4+i] <= key[32*i +: 32];
            w_r[4+i]    <= key[32*i +: 32];
          end
          init_r[12] <= ctr_lo_eff; w_r[12] <= ctr_lo_eff;
          init_r[13] <= ctr_hi_eff; w_r[13] <= ctr_hi_eff;
          init_r[14] <= nonce01[63:32]; w_r[14] <= nonce01[63:32];
          init_r[15] <= nonce2; w_r[15] <= nonce2;
        end
      end
      ST_ROUND: for (int i = 0; i < 16; i++) w_r[i] <= hr[i];
      ST_FEED:  for (int i = 0; i < 16; i++) ks_r[i] <= w_r[i] + init_r[i];
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          ob_r <= cur_r.data ^ ks_byte;
          ol_r <= cur_r.last;
        end
      end
      default: ;
    endcase
  end
endmodule

// ----- hw/rtl/chacha20_keystream_xor.sv -----
// ChaCha20 keystream XOR top level: configuration registers, input queue, cipher core
// Each input byte is XORed with the next keystream byte. A byte that finds keystream
// left in the buffer is popped and then written to the result register; a byte that
// needs a new 64-byte block first runs through the round unit, which does one half
// round per cycle, then through the feed-forward and the result register. A two-entry
// queue in front keeps the input side taking items while the core works.
module chacha20_keystream_xor import cc20_pkg::*; #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // restart
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // result_byte
  output logic        out_tlast,  // last_out
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  logic [255:0] key_r;
  logic [63:0]  nonce01_r, start_r;
  logic [31:0]  nonce2_r;
  cc20_item_t   in_item, q_item;
  logic         q_valid, q_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0; nonce01_r <= '0; nonce2_r <= '0; start_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY0:   key_r[63:0]    <= cfg_wdata;
        REG_KEY1:   key_r[127:64]  <= cfg_wdata;
        REG_KEY2:   key_r[191:128] <= cfg_wdata;
        REG_KEY3:   key_r[255:192] <= cfg_wdata;
        REG_NONCE0: nonce01_r      <= cfg_wdata;
        REG_NONCE1: nonce2_r       <= cfg_wdata[31:0];
        REG_START:  start_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_item = '{data: in_tdata, restart: in_tuser, last: in_tlast};

  cc20_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  cc20_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
    .clk(clk), .rst_n(rst_n), .key(key_r), .nonce01(nonce01_r), .nonce2(nonce2_r),
    .start_ctr(start_r), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_byte(out_tdata),
    .out_last(out_tlast)
  );
endmodule

// ----- hw/rtl/cc20_checker.sv -----
// Port-level checks for the ChaCha20 keystream block
`include "assert_macros.svh"
module cc20_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);
  `CHK_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  `CHK_IMPLY(a_valid_known, clk, rst_n, 1'b1, !$isunknown(out_tvalid))
  `CHK_IMPLY(a_ready_known, clk, rst_n, 1'b1, !$isunknown(in_tready))
endmodule

bind chacha20_keystream_xor cc20_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);

// ----- verif/chacha20_keystream_xor_tb.sv -----
// Self-checking testbench for the ChaCha20 keystream XOR block
module chacha20_keystream_xor_tb;
  import cc20_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DROUNDS = 10;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // data_byte
  logic        in_tuser = 1'b0; // restart
  logic        in_tlast = 1'b0; // end_of_message
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // result_byte
  logic        out_tlast;       // last_out
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  chacha20_keystream_xor #(.DOUBLE_ROUNDS(DROUNDS)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Keystream predictor and store of expected cipher bytes
  class keystream_scoreboard;
    logic [63:0] key_regs [4];
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;
    logic [63:0] start_ctr;
    logic [31:0] ctr_low;
    logic [31:0] ctr_nonce;
    logic [31:0] ks_words [16];
    int          pos;
    cipher_out_t pending [$];

    function new();
      foreach (key_regs[i]) key_regs[i] = '0;
      nonce_lo = '0; nonce_hi = '0; start_ctr = '0;
      ctr_low = '0; ctr_nonce = '0; pos = 64;
      foreach (ks_words[i]) ks_words[i] = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        REG_KEY0:   key_regs[0] = val;
        REG_KEY1:   key_regs[1] = val;
        REG_KEY2:   key_regs[2] = val;
        REG_KEY3:   key_regs[3] = val;
        REG_NONCE0: nonce_lo = val;
        REG_NONCE1: nonce_hi = val[31:0];
        REG_START:  start_ctr = val;
        default: ;
      endcase
    endfunction

    function logic [31:0] rol(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void mix(ref logic [31:0] x [16], input int a, int b, int c, int d);
      x[a] += x[b]; x[d] = rol(x[d] ^ x[a], 16);
      x[c] += x[d]; x[b] = rol(x[b] ^ x[c], 12);
      x[a] += x[b]; x[d] = rol(x[d] ^ x[a], 8);
      x[c] += x[d]; x[b] = rol(x[b] ^ x[c], 7);
    endfunction

    // Run the rounds, add the input state, then advance the counter
    function void next_block();
      logic [31:0] init [16];
      logic [31:0] w [16];
      init[0] = 32'h61707865; init[1] = 32'h3320646e;
      init[2] = 32'h79622d32; init[3] = 32'h6b206574;
      for (int k = 0; k < 4; k++) begin
        init[4 + 2*k] = key_regs[k][31:0];
        init[5 + 2*k] = key_regs[k][63:32];
      end
      init[12] = ctr_low; init[13] = ctr_nonce;
      init[14] = nonce_lo[63:32]; init[15] = nonce_hi;
      w = init;
      for (int r = 0; r < DROUNDS; r++) begin
        mix(w, 0, 4, 8, 12); mix(w, 1, 5, 9, 13);
        mix(w, 2, 6, 10, 14); mix(w, 3, 7, 11, 15);
        mix(w, 0, 5, 10, 15); mix(w, 1, 6, 11, 12);
        mix(w, 2, 7, 8, 13); mix(w, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) ks_words[i] = w[i] + init[i];
      ctr_low++;
      if (ctr_low == 0) ctr_nonce++;
    endfunction

    function void note_input(logic [7:0] d, logic rs, logic eom);
      cipher_out_t e;
      if (rs) begin
        ctr_low = start_ctr[31:0];
        ctr_nonce = nonce_lo[31:0] + start_ctr[63:32];
        pos = 64;
      end
      if (pos >= 64) begin
        next_block();
        pos = 0;
      end
      e.data = d ^ ks_words[pos / 4][8*(pos % 4) +: 8];
      e.last = eom;
      pos++;
      pending.push_back(e);
    endfunction

    task check_result(logic [7:0] d, logic l);
      cipher_out_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected item", d, 0);
        return;
      end
      e = pending.pop_front();
      if (d !== e.data) report_mismatch("result_byte", d, e.data);
      if (l !== e.last) report_mismatch("last_out", l, e.last);
    endtask
  endclass

  keystream_scoreboard sb = new();

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Check accepted results, stall the receiver at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_cfg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] d, input logic rs, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1; in_tdata <= d; in_tuser <= rs; in_tlast <= eom;
    do @(posedge clk); while (!in_tready);
    sb.note_input(d, rs, eom);
  endtask

  // Let the pipeline drain before touching the registers
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DROUNDS + 20) @(posedge clk);
  endtask

  task automatic random_setup(input bit extreme, input bit near_wrap);
    logic [63:0] v;
    for (int r = 0; r < 7; r++) begin
      v = {$urandom, $urandom};
      if (extreme) v = (r % 2) ? '1 : '0;
      if (near_wrap && r == REG_START) v = {$urandom, 32'hffff_fffe};
      if (near_wrap && r == REG_NONCE0) v = {$urandom, 32'hffff_ffff};
      write_cfg(r[2:0], v);
    end
  endtask

  task automatic random_message(input int len);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(255)), (i == 0), (i == len - 1));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: bytes before any restart use zero counters, field extremes
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b1);
    send_byte(8'ha5, 1'b1, 1'b0);
    send_byte(8'h5a, 1'b1, 1'b1);
    drain();
    // Registers alternately all-zeros and all-ones, low counter word at its maximum
    random_setup(1'b1, 1'b0);
    write_cfg(REG_START, 64'h0000_0001_ffff_ffff);
    for (int i = 0; i < 20; i++) send_byte(8'(i * 13), (i == 0), (i == 19));
    drain();
    // Live key and nonce change without restart
    write_cfg(REG_KEY2, 64'h0123_4567_89ab_cdef);
    write_cfg(REG_NONCE1, 64'hdead_beef);
    for (int i = 0; i < 70; i++) send_byte(8'($urandom_range(255)), 1'b0, (i == 69));
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 75 : 0;
      recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 33 : 0;
      for (int m = 0; m < 4; m++) begin
        drain();
        random_setup(m == 3 && ph == 2, m == 1);
        random_message($urandom_range(1, 100));
        // Continue the stream without restart, sometimes with a mid-stream restart
        for (int i = 0; i < 15; i++)
          send_byte(8'($urandom_range(255)), ($urandom_range(9) == 0),
                    1'($urandom_range(1)));
      end
    end
    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/cc20_pkg.sv
hw/rtl/cc20_front.sv
hw/rtl/cc20_core.sv
hw/rtl/chacha20_keystream_xor.sv
hw/rtl/cc20_checker.sv
verif/chacha20_keystream_xor_tb.sv
